### hdl/amds_pkg.sv
// Package for the array duplicate and mode statistics block.
// Holds the field widths, the duplicate saturation limit and the compare-unit control type.
// No dependencies.
package amds_pkg;

  // Widths of the transfer fields.
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned DUP_W   = 7;

  // The duplicate total saturates at the largest value its field can hold.
  localparam logic [DUP_W-1:0] DUP_MAX = 7'd127;

  // Control for the shared compare-and-count unit, driven by the sequencer.
  typedef struct packed {
    logic clear;    // Start a new count for the current reference element.
    logic vld;      // Read data holds an element to compare this cycle.
    logic earlier;  // The element under compare sits before the reference index.
  } amds_cmp_ctl_t;

endpackage

### hdl/amds_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Used for the element store. No dependencies.
module amds_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hdl/amds_cmp.sv
// Shared compare-and-count unit: one equality comparator and one counter.
// Depends on amds_pkg for the control struct and the value width.
module amds_cmp
  import amds_pkg::*;
#(
  parameter int unsigned CNT_W = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  amds_cmp_ctl_t      ctl,
  input  logic [VALUE_W-1:0] ref_value,
  input  logic [VALUE_W-1:0] rd_value,
  output logic [CNT_W-1:0]   match_cnt,
  output logic               is_first
);

  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             first_r, first_nxt;
  logic             hit;

  assign hit = ctl.vld && (rd_value == ref_value);

  // Count every match; an earlier match means the reference is not a first occurrence.
  always_comb begin
    cnt_nxt   = cnt_r;
    first_nxt = first_r;
    if (ctl.clear) begin
      cnt_nxt   = '0;
      first_nxt = 1'b1;
    end else if (hit) begin
      cnt_nxt = cnt_r + CNT_W'(1);
      if (ctl.earlier) begin
        first_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= '0;
      first_r <= 1'b1;
    end else begin
      cnt_r   <= cnt_nxt;
      first_r <= first_nxt;
    end
  end

  assign match_cnt = cnt_r;
  assign is_first  = first_r;

endmodule

### hdl/array_duplicate_and_mode_stats.sv
// Array duplicate and mode statistics: top level with the sequencer.
// Depends on amds_pkg, amds_ram and amds_cmp.
//
// Elements are written one per transfer on start while busy is low; busy stays low until
// a transfer with in_is_last set. Up to MAX_ELEMENTS elements are kept; later ones are
// dropped, but a final element still closes the array. After the final element the block
// is busy while one comparator scans every pair through the single read port of the
// element store: for each reference element it reads and loads the reference, streams
// the whole store through the comparator, drains it and evaluates the count. The result
// then appears on out_valid for exactly one cycle and the block is ready again.
// The result cannot be held off by the receiver, so it must be captured when out_valid is high.
module array_duplicate_and_mode_stats
  import amds_pkg::*;
#(
  parameter int unsigned MAX_ELEMENTS = 128
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  logic signed [VALUE_W-1:0] in_sample_value,
  input  logic                      in_is_last,
  output logic                      out_valid,
  output logic [DUP_W-1:0]          out_duplicate_total,
  output logic signed [VALUE_W-1:0] out_mode_value
);

  localparam int unsigned AW = $clog2(MAX_ELEMENTS);
  localparam int unsigned CW = $clog2(MAX_ELEMENTS + 1);
  localparam int unsigned DW = (CW > DUP_W) ? CW : DUP_W;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD_REF,
    ST_LD_REF,
    ST_SCAN,
    ST_EVAL
  } state_t;

  state_t             state_r, state_nxt;
  logic [CW-1:0]      elem_cnt_r, elem_cnt_nxt;
  logic [CW-1:0]      ref_idx_r, ref_idx_nxt;
  logic [CW-1:0]      scan_idx_r, scan_idx_nxt;
  logic [CW-1:0]      cmp_idx_r, cmp_idx_nxt;
  logic               cmp_vld_r, cmp_vld_nxt;
  logic [CW-1:0]      distinct_r, distinct_nxt;
  logic [CW-1:0]      best_r, best_nxt;
  logic [VALUE_W-1:0] ref_val_r, ref_val_nxt;
  logic [VALUE_W-1:0] mode_r, mode_nxt;
  logic [DUP_W-1:0]   dup_r, dup_nxt;
  logic               out_valid_r, out_valid_nxt;

  logic               accept;
  logic               store_we;
  logic [AW-1:0]      rd_addr;
  logic [VALUE_W-1:0] rd_data;
  logic               issue;
  amds_cmp_ctl_t      cmp_ctl;
  logic [CW-1:0]      match_cnt;
  logic               is_first;
  logic [CW-1:0]      dup_full;
  logic [DW-1:0]      dup_ext;

  assign busy     = (state_r != ST_IDLE);
  assign accept   = start && !busy;
  assign store_we = accept && (elem_cnt_r < CW'(MAX_ELEMENTS));
  assign issue    = (state_r == ST_SCAN) && (scan_idx_r < elem_cnt_r);

  // Read address: the reference element, then a stream over the whole store.
  assign rd_addr = (state_r == ST_RD_REF) ? ref_idx_r[AW-1:0] : scan_idx_r[AW-1:0];

  amds_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (MAX_ELEMENTS)
  ) u_store (
    .clk   (clk),
    .we    (store_we),
    .waddr (elem_cnt_r[AW-1:0]),
    .wdata (in_sample_value),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  // Compare-unit valid and index are registered alongside the store read, so they line up with the read data.
  always_comb begin
    cmp_ctl.clear   = (state_r == ST_LD_REF);
    cmp_ctl.vld     = cmp_vld_r;
    cmp_ctl.earlier = (cmp_idx_r < ref_idx_r);
  end

  amds_cmp #(
    .CNT_W (CW)
  ) u_cmp (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (cmp_ctl),
    .ref_value (ref_val_r),
    .rd_value  (rd_data),
    .match_cnt (match_cnt),
    .is_first  (is_first)
  );

  // Duplicate total from the distinct count including the reference under evaluation,
  // saturated to the field.
  assign dup_full = elem_cnt_r - distinct_r - CW'(is_first);
  assign dup_ext  = DW'(dup_full);

  // Sequencer: load, then for each reference index scan the store and evaluate.
  always_comb begin
    state_nxt     = state_r;
    elem_cnt_nxt  = elem_cnt_r;
    ref_idx_nxt   = ref_idx_r;
    scan_idx_nxt  = scan_idx_r;
    cmp_idx_nxt   = scan_idx_r;
    cmp_vld_nxt   = issue;
    distinct_nxt  = distinct_r;
    best_nxt      = best_r;
    ref_val_nxt   = ref_val_r;
    mode_nxt      = mode_r;
    dup_nxt       = dup_r;
    out_valid_nxt = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (store_we) begin
          elem_cnt_nxt = elem_cnt_r + CW'(1);
        end
        if (accept && in_is_last) begin
          ref_idx_nxt  = '0;
          distinct_nxt = '0;
          best_nxt     = '0;
          state_nxt    = ST_RD_REF;
        end
      end
      ST_RD_REF: begin
        state_nxt = ST_LD_REF;
      end
      ST_LD_REF: begin
        ref_val_nxt  = rd_data;
        scan_idx_nxt = '0;
        state_nxt    = ST_SCAN;
      end
      ST_SCAN: begin
        if (issue) begin
          scan_idx_nxt = scan_idx_r + CW'(1);
        end else if (!cmp_vld_r) begin
          state_nxt = ST_EVAL;
        end
      end
      ST_EVAL: begin
        if (is_first) begin
          distinct_nxt = distinct_r + CW'(1);
          if (match_cnt > best_r) begin
            best_nxt = match_cnt;
            mode_nxt = ref_val_r;
          end
        end
        ref_idx_nxt = ref_idx_r + CW'(1);
        if (ref_idx_nxt == elem_cnt_r) begin
          dup_nxt       = (dup_ext > DW'(DUP_MAX)) ? DUP_MAX : dup_ext[DUP_W-1:0];
          out_valid_nxt = 1'b1;
          elem_cnt_nxt  = '0;
          state_nxt     = ST_IDLE;
        end else begin
          state_nxt = ST_RD_REF;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // State, control and registered outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      elem_cnt_r  <= '0;
      cmp_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      elem_cnt_r  <= elem_cnt_nxt;
      cmp_vld_r   <= cmp_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
    ref_idx_r  <= ref_idx_nxt;
    scan_idx_r <= scan_idx_nxt;
    cmp_idx_r  <= cmp_idx_nxt;
    distinct_r <= distinct_nxt;
    best_r     <= best_nxt;
    ref_val_r  <= ref_val_nxt;
    mode_r     <= mode_nxt;
    dup_r      <= dup_nxt;
  end

  assign out_valid           = out_valid_r;
  assign out_duplicate_total = dup_r;
  assign out_mode_value      = mode_r;

`ifndef SYNTHESIS
  // A result is a single-cycle transfer and is never followed directly by another.
  a_single_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result transfer lasted more than one cycle");

  // An element that does not close the array produces no result.
  a_no_result_mid_array: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && !in_is_last) |=> !out_valid)
    else $error("result issued for an element that was not the last");

  // The store is emptied together with the result.
  a_store_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (elem_cnt_r == '0) && !busy)
    else $error("element count not cleared with the result");

  // The scan never runs past the stored element count.
  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> (scan_idx_r <= elem_cnt_r))
    else $error("scan index beyond the stored elements");
`endif

endmodule

### test/tb_array_duplicate_and_mode_stats.sv
// Self-checking testbench for array_duplicate_and_mode_stats.
// Depends on amds_pkg and the block's RTL. A tracker class predicts the duplicate total and
// the mode of each array, and checks every result strobe against the oldest prediction.
module tb_array_duplicate_and_mode_stats
  import amds_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MAX_KEPT     = 128;
  localparam int unsigned ITEM_TARGET  = 950;
  localparam int unsigned STALL_LIMIT  = 100000;
  localparam int unsigned DRAIN_CYCLES = 40;

  typedef struct packed {
    logic [DUP_W-1:0]   dup_total;
    logic [VALUE_W-1:0] mode;
  } array_stats_t;

  // Tracks the array being loaded and the statistics still owed by the block.
  class mode_stats_tracker;
    logic [VALUE_W-1:0] kept[$];
    array_stats_t       expected_stats[$];
    int unsigned        errors;
    int unsigned        checked;

    function new();
      errors  = 0;
      checked = 0;
    endfunction

    // Duplicate total and mode over the kept elements; each value is counted once.
    function array_stats_t compute_stats();
      array_stats_t s;
      bit           counted[MAX_KEPT];
      int unsigned  n;
      int unsigned  dups;
      int unsigned  best;
      int unsigned  c;
      n    = kept.size();
      dups = 0;
      best = 0;
      s.mode = (n > 0) ? kept[0] : '0;
      for (int i = 0; i < MAX_KEPT; i++) counted[i] = 1'b0;
      for (int i = 0; i < n; i++) begin
        if (counted[i]) continue;
        c = 0;
        for (int j = 0; j < n; j++) begin
          if (kept[j] == kept[i]) begin
            c++;
            counted[j] = 1'b1;
          end
        end
        dups += c - 1;
        // Strictly greater, so the earliest first occurrence keeps a tie.
        if (c > best) begin
          best   = c;
          s.mode = kept[i];
        end
      end
      s.dup_total = (dups > DUP_MAX) ? DUP_MAX : dups[DUP_W-1:0];
      return s;
    endfunction

    // An element transfer; a full store drops it, but a final element still closes the array.
    function void note_element(logic [VALUE_W-1:0] v, logic last);
      if (kept.size() < MAX_KEPT) kept.push_back(v);
      if (last) begin
        expected_stats.push_back(compute_stats());
        kept.delete();
      end
    endfunction

    function void check_stats(logic [DUP_W-1:0] dup_total, logic [VALUE_W-1:0] mode);
      array_stats_t e;
      if (expected_stats.size() == 0) begin
        $error("result with no array pending: duplicate_total=%0d mode_value=%0d",
               dup_total, $signed(mode));
        errors++;
        return;
      end
      e = expected_stats.pop_front();
      checked++;
      if (dup_total !== e.dup_total) begin
        $error("duplicate_total: expected %0d, actual %0d", e.dup_total, dup_total);
        errors++;
      end
      if (mode !== e.mode) begin
        $error("mode_value: expected %0d, actual %0d", $signed(e.mode), $signed(mode));
        errors++;
      end
    endfunction

    function int unsigned pending();
      return expected_stats.size();
    endfunction
  endclass

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      start = 1'b0;
  logic                      busy;
  logic signed [VALUE_W-1:0] in_sample_value = '0;
  logic                      in_is_last = 1'b0;
  logic                      out_valid;
  logic [DUP_W-1:0]          out_duplicate_total;
  logic signed [VALUE_W-1:0] out_mode_value;

  mode_stats_tracker tracker = new();
  int unsigned       elements_sent = 0;
  int unsigned       arrays_sent = 0;
  int unsigned       burst_left = 0;
  int unsigned       quiet_cycles = 0;

  array_duplicate_and_mode_stats #(.MAX_ELEMENTS(MAX_KEPT)) i_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .busy                (busy),
    .in_sample_value     (in_sample_value),
    .in_is_last          (in_is_last),
    .out_valid           (out_valid),
    .out_duplicate_total (out_duplicate_total),
    .out_mode_value      (out_mode_value)
  );

  // 4 ns clock.
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Monitor: results are checked before the input of the same edge is noted.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid) tracker.check_stats(out_duplicate_total, out_mode_value);
      if (start && !busy) tracker.note_element(in_sample_value, in_is_last);
    end
  end

  // Watchdog on cycles without any transfer in either direction.
  always @(posedge clk) begin
    if (!rst_n || out_valid || (start && !busy)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Idle cycles with noise on the data ports, which the block must ignore.
  task automatic idle_cycles(int unsigned k);
    repeat (k) begin
      @(negedge clk);
      start           <= 1'b0;
      in_sample_value <= $urandom();
      in_is_last      <= $urandom_range(0, 1);
    end
  endtask

  // One element transfer; start stays high until the block takes it.
  task automatic send_element(logic [VALUE_W-1:0] v, logic last);
    @(negedge clk);
    start           <= 1'b1;
    in_sample_value <= v;
    in_is_last      <= last;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    elements_sent++;
    if (last) arrays_sent++;
  endtask

  // Sender with bursts of random length and random gaps; some bursts run long without gaps.
  task automatic paced_element(logic [VALUE_W-1:0] v, logic last);
    if (burst_left == 0) begin
      if ($urandom_range(0, 3) == 0) begin
        burst_left = $urandom_range(40, 120);
      end else begin
        idle_cycles($urandom_range(1, 9));
        burst_left = $urandom_range(1, 20);
      end
    end
    burst_left--;
    send_element(v, last);
  endtask

  task automatic send_array(logic [VALUE_W-1:0] vals[$]);
    foreach (vals[i]) paced_element(vals[i], i == vals.size() - 1);
  endtask

  // Random array of the given length drawn from one of several value styles.
  task automatic random_array(int unsigned len);
    logic [VALUE_W-1:0] pool[$];
    logic [VALUE_W-1:0] vals[$];
    int unsigned        style;
    int unsigned        pool_size;
    style     = $urandom_range(0, 3);
    pool_size = $urandom_range(1, 5);
    case (style)
      0: begin
        for (int i = 0; i < pool_size; i++) pool.push_back($urandom());
      end
      1: begin
        pool = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF};
      end
      2: begin
        for (int i = 0; i < pool_size; i++) pool.push_back($urandom_range(0, 3) - 2);
      end
      default: begin
        pool.delete();
      end
    endcase
    for (int i = 0; i < len; i++) begin
      if (pool.size() == 0) vals.push_back($urandom());
      else vals.push_back(pool[$urandom_range(0, pool.size() - 1)]);
    end
    send_array(vals);
  endtask

  initial begin
    logic [VALUE_W-1:0] vals[$];
    int unsigned        big_done;
    big_done = 0;

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed arrays: a single element, the extremes, ties and a clear winner.
    send_array('{32'd7});
    send_array('{32'h8000_0000, 32'h8000_0000});
    send_array('{32'h7FFF_FFFF, 32'h0, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF});
    send_array('{32'd5, 32'd3, 32'd3, 32'd5});
    send_array('{32'd1, 32'd2, 32'd3, 32'd2, 32'd3, 32'd3});
    send_array('{32'h5555_5555, 32'hAAAA_AAAA});

    // Hold the sender until every owed result has come back.
    @(negedge clk);
    start <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);

    // Random arrays, mostly short, with a few at or near the store size.
    while (elements_sent < ITEM_TARGET) begin
      if (big_done < 3 && elements_sent >= 200 + 300 * big_done) begin
        if (big_done == 0) begin
          // All equal past the store size: the largest total, with the final element dropped.
          vals.delete();
          repeat (MAX_KEPT + 2) vals.push_back(32'hDEAD_BEEF);
          send_array(vals);
        end else begin
          random_array($urandom_range(MAX_KEPT - 1, MAX_KEPT + 6));
        end
        big_done++;
      end else begin
        random_array($urandom_range(1, 16));
      end
    end

    @(negedge clk);
    start <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d elements in %0d arrays, %0d results checked,", elements_sent,
             arrays_sent, tracker.checked);
    $display("including ties, extreme values and arrays that overflow the store.");
    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

### array_duplicate_and_mode_stats.f
hdl/amds_pkg.sv
hdl/amds_ram.sv
hdl/amds_cmp.sv
hdl/array_duplicate_and_mode_stats.sv
test/tb_array_duplicate_and_mode_stats.sv
